FILE: rtl/core/spds_pkg.sv
`default_nettype none
package spds_pkg;
  localparam int unsigned Reach = 15;
  localparam int unsigned WinDepth = 2 * Reach;
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned WinIdxW = $clog2(WinDepth);
  localparam int unsigned PendIdxW = $clog2(Reach);
  localparam int unsigned PixW = 8;
  localparam int unsigned CostW = 2 * PixW;
  localparam int unsigned DispW = 5;

  // reciprocals in 16 fractional bits, rounded up: exact quotient for ColW-bit columns
  localparam int unsigned RecipShift = 16;
  localparam int unsigned WinRecip = ((1 << RecipShift) + WinDepth - 1) / WinDepth;
  localparam int unsigned ReachRecip = ((1 << RecipShift) + Reach - 1) / Reach;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             store;     // write accepted pixels
    logic             start;     // begin search for column x
    logic [ColW-1:0]  x;
    logic [ColW-1:0]  last_col;
    logic             step;      // evaluate one candidate
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             done;      // all candidates evaluated
    logic [ColW-1:0]  best_col;
  } sts_t;

  // column modulo window depth via reciprocal multiply
  function automatic logic [WinIdxW-1:0] win_slot(input logic [ColW-1:0] col);
    logic [ColW+12:0] prod;
    logic [ColW-1:0]  quo;
    prod = (ColW+13)'(col) * (ColW+13)'(WinRecip);
    quo = ColW'(prod >> RecipShift);
    return WinIdxW'(col - quo * ColW'(WinDepth));
  endfunction

  // column modulo reach via reciprocal multiply
  function automatic logic [PendIdxW-1:0] pend_slot(input logic [ColW-1:0] col);
    logic [ColW+12:0] prod;
    logic [ColW-1:0]  quo;
    prod = (ColW+13)'(col) * (ColW+13)'(ReachRecip);
    quo = ColW'(prod >> RecipShift);
    return PendIdxW'(col - quo * ColW'(Reach));
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/spds_if.sv
`default_nettype none
interface spds_in_if;
  logic valid;
  logic ready;
  logic [7:0] left_pixel;
  logic [7:0] right_pixel;
  logic row_end;
  modport source (output valid, left_pixel, right_pixel, row_end, input ready);
  modport sink (input valid, left_pixel, right_pixel, row_end, output ready);
endinterface

interface spds_out_if;
  logic valid;
  logic ready;
  logic signed [4:0] disparity;
  logic [10:0] column;
  logic last_of_row;
  modport source (output valid, disparity, column, last_of_row, input ready);
  modport sink (input valid, disparity, column, last_of_row, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spds_ram.sv
`default_nettype none
module spds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/spds_datapath.sv
`default_nettype none
module spds_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire spds_pkg::cmd_t                cmd,
  input  wire logic [spds_pkg::ColW-1:0]     wr_col,
  input  wire logic [spds_pkg::PixW-1:0]     left_in,
  input  wire logic [spds_pkg::PixW-1:0]     right_in,
  output      spds_pkg::sts_t                sts
);
  logic [spds_pkg::ColW:0]   rcol_r, rcol_nxt;   // column being read, one spare bit
  logic [spds_pkg::ColW-1:0] hi_r, hi_nxt;
  logic [spds_pkg::ColW-1:0] eval_col_r, eval_col_nxt;  // column whose pixel is in rdata
  logic                      eval_v_r, eval_v_nxt;
  logic                      have_r, have_nxt;
  logic [spds_pkg::CostW-1:0] best_cost_r, best_cost_nxt;
  logic [spds_pkg::ColW-1:0] best_r, best_nxt;
  logic [spds_pkg::PixW-1:0] lp_r;
  logic                      lp_sel_r;
  logic [spds_pkg::PixW-1:0] win_q, pend_q;
  logic [spds_pkg::ColW-1:0] lo;
  logic [spds_pkg::ColW:0]   hi_full;
  logic [spds_pkg::ColW-1:0] hi_c;
  logic [spds_pkg::ColW-1:0] rd_col;
  logic [spds_pkg::PixW-1:0] lp, diff;
  logic [spds_pkg::CostW-1:0] cost;
  logic                      reading;

  // ring addressing: window modulo 30, pending modulo 15
  logic [spds_pkg::WinIdxW-1:0]  win_wa, win_ra;
  logic [spds_pkg::PendIdxW-1:0] pend_wa, pend_ra;

  assign win_wa  = spds_pkg::win_slot(wr_col);
  assign pend_wa = spds_pkg::pend_slot(wr_col);
  assign pend_ra = spds_pkg::pend_slot(cmd.x);

  assign lo = (cmd.x >= spds_pkg::ColW'(spds_pkg::Reach)) ?
              cmd.x - spds_pkg::ColW'(spds_pkg::Reach) : '0;
  assign hi_full = {1'b0, cmd.x} + (spds_pkg::ColW+1)'(spds_pkg::Reach - 1);
  assign hi_c = (hi_full > {1'b0, cmd.last_col}) ? cmd.last_col
                                                 : spds_pkg::ColW'(hi_full);

  assign reading = cmd.step && (rcol_r <= {1'b0, hi_r}) && !cmd.start;
  assign rd_col = cmd.start ? lo : rcol_r[spds_pkg::ColW-1:0];
  assign win_ra = spds_pkg::win_slot(rd_col);

  spds_ram #(.Width(spds_pkg::PixW), .Depth(spds_pkg::WinDepth)) u_win (
    .clk(clk), .we(cmd.store), .waddr(win_wa), .wdata(right_in),
    .raddr(win_ra), .rdata(win_q));

  spds_ram #(.Width(spds_pkg::PixW), .Depth(spds_pkg::Reach)) u_pend (
    .clk(clk), .we(cmd.store), .waddr(pend_wa), .wdata(left_in),
    .raddr(pend_ra), .rdata(pend_q));

  assign lp = lp_sel_r ? pend_q : lp_r;
  assign diff = (lp >= win_q) ? lp - win_q : win_q - lp;
  assign cost = diff * diff;

  always_comb begin
    rcol_nxt = rcol_r;
    hi_nxt = hi_r;
    eval_col_nxt = eval_col_r;
    eval_v_nxt = 1'b0;
    have_nxt = have_r;
    best_cost_nxt = best_cost_r;
    best_nxt = best_r;
    if (cmd.start) begin
      rcol_nxt = {1'b0, lo} + (spds_pkg::ColW+1)'(1);
      hi_nxt = hi_c;
      eval_col_nxt = lo;
      eval_v_nxt = 1'b1;
      have_nxt = 1'b0;
    end else begin
      if (eval_v_r && (!have_r || cost < best_cost_r)) begin
        have_nxt = 1'b1;
        best_cost_nxt = cost;
        best_nxt = eval_col_r;
      end
      if (reading) begin
        eval_col_nxt = rcol_r[spds_pkg::ColW-1:0];
        eval_v_nxt = 1'b1;
        rcol_nxt = rcol_r + (spds_pkg::ColW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_v_r <= 1'b0;
      have_r <= 1'b0;
      lp_sel_r <= 1'b0;
    end else begin
      eval_v_r <= eval_v_nxt;
      have_r <= have_nxt;
      lp_sel_r <= cmd.start;
    end
    rcol_r <= rcol_nxt;
    hi_r <= hi_nxt;
    eval_col_r <= eval_col_nxt;
    best_cost_r <= best_cost_nxt;
    best_r <= best_nxt;
    if (lp_sel_r) begin
      lp_r <= pend_q;
    end
  end

  assign sts.done = !cmd.start && !eval_v_r && have_r && (rcol_r > {1'b0, hi_r});
  assign sts.best_col = best_r;
endmodule
`default_nettype wire

FILE: rtl/core/spds_ctrl.sv
`default_nettype none
module spds_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  spds_in_if.sink                        in_ch,
  spds_out_if.source                     out_ch,
  output      spds_pkg::cmd_t            cmd,
  output      logic [spds_pkg::ColW-1:0] wr_col,
  input  wire spds_pkg::sts_t            sts
);
  spds_pkg::state_t state_r, state_nxt;
  logic [spds_pkg::ColW-1:0] col_r, col_nxt;       // next input column
  logic [spds_pkg::ColW-1:0] x_r, x_nxt;           // column being searched
  logic [spds_pkg::ColW-1:0] stop_r, stop_nxt;     // last column to emit
  logic [spds_pkg::ColW-1:0] last_r, last_nxt;     // clip limit
  logic                      flush_r, flush_nxt;
  logic                      ov_r, ov_nxt;
  logic signed [spds_pkg::DispW-1:0] disp_r, disp_nxt;
  logic [spds_pkg::ColW-1:0] ocol_r, ocol_nxt;
  logic                      olast_r, olast_nxt;
  logic                      acc, end_item;
  logic [spds_pkg::ColW-1:0] first;

  assign in_ch.ready = (state_r == spds_pkg::ST_IDLE) && !ov_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign end_item = in_ch.row_end ||
                    (col_r >= spds_pkg::ColW'(spds_pkg::MaxWidth - 1));
  assign first = (col_r >= spds_pkg::ColW'(spds_pkg::Reach - 1)) ?
                 col_r - spds_pkg::ColW'(spds_pkg::Reach - 1) : '0;
  assign wr_col = col_r;

  assign out_ch.valid = ov_r;
  assign out_ch.disparity = disp_r;
  assign out_ch.column = ocol_r;
  assign out_ch.last_of_row = olast_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    x_nxt = x_r;
    stop_nxt = stop_r;
    last_nxt = last_r;
    flush_nxt = flush_r;
    ov_nxt = ov_r && !out_ch.ready;
    disp_nxt = disp_r;
    ocol_nxt = ocol_r;
    olast_nxt = olast_r;
    cmd = '0;
    cmd.x = x_r;
    cmd.last_col = last_r;
    cmd.store = acc;
    case (state_r)
      spds_pkg::ST_IDLE: begin
        if (acc) begin
          x_nxt = first;
          last_nxt = col_r;
          stop_nxt = end_item ? col_r : first;
          flush_nxt = end_item;
          col_nxt = end_item ? '0 : col_r + spds_pkg::ColW'(1);
          if (end_item || col_r >= spds_pkg::ColW'(spds_pkg::Reach - 1)) begin
            state_nxt = spds_pkg::ST_LOAD;
          end
        end
      end
      spds_pkg::ST_LOAD: begin
        // pixels just written; launch search
        cmd.start = 1'b1;
        state_nxt = spds_pkg::ST_SEARCH;
      end
      spds_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.done && !ov_r) begin
          ov_nxt = 1'b1;
          disp_nxt = spds_pkg::DispW'(x_r - sts.best_col);
          ocol_nxt = x_r;
          olast_nxt = flush_r && (x_r == stop_r);
          state_nxt = spds_pkg::ST_OUT;
        end
      end
      spds_pkg::ST_OUT: begin
        if (x_r == stop_r) begin
          state_nxt = spds_pkg::ST_IDLE;
        end else begin
          x_nxt = x_r + spds_pkg::ColW'(1);
          state_nxt = spds_pkg::ST_LOAD;
        end
      end
      default: state_nxt = spds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spds_pkg::ST_IDLE;
      col_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt;
      ov_r <= ov_nxt;
    end
    x_r <= x_nxt;
    stop_r <= stop_nxt;
    last_r <= last_nxt;
    flush_r <= flush_nxt;
    disp_r <= disp_nxt;
    ocol_r <= ocol_nxt;
    olast_r <= olast_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/core/stereo_pixel_disparity_search.sv
// Search: each result comes from a serial scan over its clipped candidates
//   (up to 30), one candidate per cycle through the window RAM port.
// Input flow: one beat at a time; a beat yielding results holds input until its
//   last result is taken at the output; beats with no result add no hold.
//   A flush beat yields up to 15 results.
// Reset: synchronous active-low rst_n clears the state machine, column counter and
//   output valid; pixel stores are undefined until written.
`default_nettype none
module stereo_pixel_disparity_search (
  input wire logic   clk,
  input wire logic   rst_n,
  spds_in_if.sink    in_ch,
  spds_out_if.source out_ch
);
  spds_pkg::cmd_t cmd;
  spds_pkg::sts_t sts;
  logic [spds_pkg::ColW-1:0] wr_col;

  // sequencer: column tracking, emission order, output register
  spds_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cmd(cmd), .wr_col(wr_col), .sts(sts));

  // pixel rings plus serial squared-difference minimum search
  spds_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .wr_col(wr_col),
    .left_in(in_ch.left_pixel), .right_in(in_ch.right_pixel), .sts(sts));
endmodule
`default_nettype wire

FILE: test/spds_tb_if.sv
`timescale 1ns / 100ps
// Interfaces come from the RTL tree (spds_if.sv); this file declares only the testbench package.
package spds_tb_pkg;
  localparam int unsigned SearchReach = 15;
  localparam int unsigned RowLimit = 2048;
endpackage

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import spds_tb_pkg::*;

  typedef struct packed {
    logic [7:0] left_px;
    logic [7:0] right_px;
    logic       row_end;
  } pixel_beat_t;

  typedef struct packed {
    logic [4:0]  disp;
    logic [10:0] col;
    logic        last;
  } disp_beat_t;

  // Directed row: beat, plus expected first result where it is obvious.
  typedef struct packed {
    pixel_beat_t beat;
    logic        has_fixed;
    disp_beat_t  fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  spds_in_if  in_ch ();
  spds_out_if out_ch ();

  stereo_pixel_disparity_search uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Predictor state: right pixels by column and pending left pixels.
  logic [7:0]  rwin [0:2*SearchReach-1];
  logic [7:0]  lpend [0:SearchReach-1];
  int unsigned col_next;

  disp_beat_t  expected_disp_q[$];
  disp_beat_t  fixed_disp_q[$];
  int          fail_cnt;
  int          idle_pct;
  int          stall_pct;
  int          quiet_cnt;

  function automatic disp_beat_t match_column(int unsigned x, int unsigned last_col);
    int unsigned lo, hi, best, best_cost, cost, r;
    int          d;
    disp_beat_t  res;
    lo = (x >= SearchReach) ? x - SearchReach : 0;
    hi = x + SearchReach - 1;
    if (hi > last_col) hi = last_col;
    best = x;
    best_cost = 32'hFFFF_FFFF;
    for (r = lo; r <= hi; r++) begin
      d = int'(lpend[x % SearchReach]) - int'(rwin[r % (2*SearchReach)]);
      cost = d * d;
      // strict less: leftmost column wins ties
      if (cost < best_cost) begin
        best_cost = cost;
        best = r;
      end
    end
    res.disp = 5'(x - best);
    res.col = 11'(x);
    res.last = 1'b0;
    return res;
  endfunction

  task automatic predict_disparity(input pixel_beat_t b);
    int unsigned c, first, x;
    bit          flush;
    disp_beat_t  r;
    c = col_next;
    flush = b.row_end || (c >= RowLimit - 1);
    rwin[c % (2*SearchReach)] = b.right_px;
    lpend[c % SearchReach] = b.left_px;
    first = (c >= SearchReach - 1) ? c - (SearchReach - 1) : 0;
    if (flush) begin
      for (x = first; x <= c; x++) begin
        r = match_column(x, c);
        r.last = (x == c);
        expected_disp_q = {expected_disp_q, r};
      end
      col_next = 0;
    end else begin
      if (c >= SearchReach - 1) begin
        r = match_column(first, c);
        expected_disp_q = {expected_disp_q, r};
      end
      col_next = c + 1;
    end
  endtask

  // Send one beat; idles at random before it. Valid stays high afterwards
  // until the next beat or an idle cycle replaces it.
  task automatic send_pixel(input pixel_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_pixel <= b.left_px;
    in_ch.right_pixel <= b.right_px;
    in_ch.row_end <= b.row_end;
    predict_disparity(b);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_row(input int unsigned len, input bit similar);
    pixel_beat_t b;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      b.left_px = 8'($urandom);
      // mostly nearby values so the search has real structure; some flat ties
      b.right_px = similar ? 8'(b.left_px + $urandom_range(6) - 3) : 8'($urandom);
      if ($urandom_range(9) == 0) b.right_px = 8'h80;
      b.row_end = (i == len - 1);
      send_pixel(b);
    end
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_disp_q.size() != 0);
  endtask

  // Result side: random stall and check against the oldest expectation.
  always @(posedge clk) begin
    disp_beat_t got, exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.disp = out_ch.disparity;
        got.col = out_ch.column;
        got.last = out_ch.last_of_row;
        if (expected_disp_q.size() == 0) begin
          $error("unexpected beat col=%0d", got.col);
          fail_cnt++;
        end else begin
          exp_r = expected_disp_q.pop_front();
          if (fixed_disp_q.size() != 0 && fixed_disp_q[0].col == got.col) begin
            exp_r = fixed_disp_q.pop_front();
          end
          if (got.disp !== exp_r.disp) begin
            $error("disparity exp=%0d act=%0d", $signed(exp_r.disp), $signed(got.disp));
            fail_cnt++;
          end
          if (got.col !== exp_r.col) begin
            $error("column exp=%0d act=%0d", exp_r.col, got.col);
            fail_cnt++;
          end
          if (got.last !== exp_r.last) begin
            $error("last_of_row exp=%0d act=%0d", exp_r.last, got.last);
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  stim_row_t dir_tbl [8] = '{
    // single-column row at extremes: only candidate is itself
    '{'{8'hFF, 8'h00, 1'b1}, 1'b1, '{5'd0, 11'd0, 1'b1}},
    '{'{8'h00, 8'hFF, 1'b1}, 1'b1, '{5'd0, 11'd0, 1'b1}},
    // short row, all-equal: ties pick leftmost (column 0)
    '{'{8'h55, 8'h55, 1'b0}, 1'b0, '0},
    '{'{8'h55, 8'h55, 1'b0}, 1'b0, '0},
    '{'{8'h55, 8'h55, 1'b1}, 1'b0, '0},
    // short row with exact match to the right
    '{'{8'h10, 8'hF0, 1'b0}, 1'b0, '0},
    '{'{8'hAA, 8'h10, 1'b0}, 1'b0, '0},
    '{'{8'h01, 8'hAA, 1'b1}, 1'b0, '0}
  };

  initial begin
    int i, n;
    in_ch.valid = 1'b0;
    in_ch.left_pixel = '0;
    in_ch.right_pixel = '0;
    in_ch.row_end = 1'b0;
    out_ch.ready = 1'b0;
    col_next = 0;
    fail_cnt = 0;
    quiet_cnt = 0;
    idle_pct = 7;
    stall_pct = 7;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].has_fixed) fixed_disp_q = {fixed_disp_q, dir_tbl[k].fixed};
      send_pixel(dir_tbl[k].beat);
    end
    // pause the sender until every result is in
    drain_wait();

    // long rows cross the window wrap; one row without any idling
    idle_pct = 0;
    stall_pct = 0;
    send_row(40, 1'b1);
    idle_pct = 7;
    stall_pct = 7;
    n = 0;
    while (n < 110) begin
      i = ($urandom_range(3) == 0) ? $urandom_range(1, 14) : $urandom_range(15, 35);
      send_row(i, $urandom_range(3) != 0);
      n += i;
    end

    drain_wait();
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
